// File: hw/rtl/fmprf_pkg.sv
// Shared types, codes and constants of the first-match packet rule filter.
package fmprf_pkg;

  localparam int unsigned MaxRulesDef = 64;
  localparam int unsigned PosW        = 7;
  localparam int unsigned CfgIdxW     = 2;

  typedef enum logic [1:0] {
    ReqAppend   = 2'd0,
    ReqDelete   = 2'd1,
    ReqClear    = 2'd2,
    ReqClassify = 2'd3
  } req_type_e;

  localparam logic [1:0] ProtoTcp   = 2'd0;
  localparam logic [1:0] ProtoUdp   = 2'd1;
  localparam logic [1:0] ProtoIcmp  = 2'd2;
  localparam logic [1:0] ProtoOther = 2'd3;
  localparam logic [1:0] ProtoAny   = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoIndex = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgDefaultAccept = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFilterEnable  = CfgIdxW'(1);

  typedef struct packed {
    logic [1:0]      req_type;
    logic [1:0]      ip_proto;
    logic [31:0]     src_addr;
    logic [31:0]     dst_addr;
    logic [15:0]     src_port;
    logic [15:0]     dst_port;
    logic [1:0]      rule_proto;
    logic            rule_accept;
    logic [PosW-1:0] rule_index;
  } req_t;

  typedef struct packed {
    logic            verdict_accept;
    logic [1:0]      status;
    logic            rule_hit;
    logic [PosW-1:0] hit_position;
    logic [PosW-1:0] rules_held;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic               data;
  } cfg_t;

  typedef struct packed {
    logic        accept;
    logic [1:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } rule_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic scan;
    logic shift;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_scan;
    logic go_shift;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hw/rtl/fmprf_chan_if.sv
// Valid/ready channel interface with a typed payload.
interface fmprf_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/fmprf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fmprf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fmprf_ctrl.sv
// Request sequencer of the rule filter: decode, scan, shift and response.
module fmprf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  fmprf_pkg::dp_sts_t   sts_i,
  output fmprf_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StScan,
    StShift,
    StResp
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (req_valid_i) state_q <= StDecode;
        end
        StDecode: begin
          if (sts_i.go_scan) state_q <= StScan;
          else if (sts_i.go_shift) state_q <= StShift;
          else state_q <= StResp;
        end
        StScan: begin
          if (sts_i.scan_done) state_q <= StResp;
        end
        StShift: begin
          if (sts_i.shift_done) state_q <= StResp;
        end
        StResp: begin
          if (sts_i.out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign req_ready_o    = (state_q == StIdle);
  assign cmd_o.capture  = (state_q == StIdle) && req_valid_i;
  assign cmd_o.decode   = (state_q == StDecode);
  assign cmd_o.scan     = (state_q == StScan);
  assign cmd_o.shift    = (state_q == StShift);
  assign cmd_o.load_out = (state_q == StResp) && sts_i.out_free;

endmodule

// File: hw/rtl/fmprf_dp.sv
// Datapath of the rule filter: request register, rule RAM, scan and result registers.
module fmprf_dp #(
  parameter int unsigned MAX_RULES = fmprf_pkg::MaxRulesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fmprf_pkg::req_t      req_i,
  input  logic                 default_accept_i,
  input  logic                 filter_enable_i,
  input  fmprf_pkg::ctrl_cmd_t cmd_i,
  output fmprf_pkg::dp_sts_t   sts_o,
  input  logic                 rsp_ready_i,
  output logic                 rsp_valid_o,
  output fmprf_pkg::rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(MAX_RULES + 1);
  localparam int unsigned IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CmpW = (CntW > fmprf_pkg::PosW) ? CntW : fmprf_pkg::PosW;

  fmprf_pkg::req_t  rq_q, rq_d;
  fmprf_pkg::rsp_t  res_q, res_d;
  fmprf_pkg::rsp_t  out_q, out_d;
  logic             out_vld_q, out_vld_d;
  logic [CntW-1:0]  total_q, total_d;
  logic [CntW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  chk_pos_q, chk_pos_d;
  logic             chk_vld_q, chk_vld_d;

  fmprf_pkg::rule_t rd_rule, wr_rule, new_rule;
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  wr_addr, rd_addr;
  logic [CntW-1:0]  shift_pos;

  logic             full, bad_del, scan_ok, more, match, hit_now;
  logic [CmpW-1:0]  ridx_ext, total_ext;
  logic [15:0]      pkt_sport, pkt_dport;

  // request decode
  assign full      = (total_q == CntW'(MAX_RULES));
  assign ridx_ext  = CmpW'(rq_q.rule_index);
  assign total_ext = CmpW'(total_q);
  assign bad_del   = (rq_q.rule_index == '0) || (ridx_ext > total_ext);
  assign scan_ok   = filter_enable_i && (rq_q.ip_proto != fmprf_pkg::ProtoOther);
  assign more      = (rd_ptr_q < total_q);

  // rule compare on the entry returned by the RAM
  assign pkt_sport = (rq_q.ip_proto == fmprf_pkg::ProtoIcmp) ? 16'd0 : rq_q.src_port;
  assign pkt_dport = (rq_q.ip_proto == fmprf_pkg::ProtoIcmp) ? 16'd0 : rq_q.dst_port;
  assign match = ((rd_rule.proto == rq_q.ip_proto) || (rd_rule.proto == fmprf_pkg::ProtoAny))
              && ((rd_rule.src_addr == '0) || (rd_rule.src_addr == rq_q.src_addr))
              && ((rd_rule.src_port == '0) || (rd_rule.src_port == pkt_sport))
              && ((rd_rule.dst_addr == '0) || (rd_rule.dst_addr == rq_q.dst_addr))
              && ((rd_rule.dst_port == '0) || (rd_rule.dst_port == pkt_dport));
  assign hit_now = chk_vld_q && match;

  assign sts_o.go_scan    = (rq_q.req_type == fmprf_pkg::ReqClassify) && scan_ok;
  assign sts_o.go_shift   = (rq_q.req_type == fmprf_pkg::ReqDelete) && !bad_del;
  assign sts_o.scan_done  = hit_now || (!more && !chk_vld_q);
  assign sts_o.shift_done = !more && !chk_vld_q;
  assign sts_o.out_free   = !out_vld_q || rsp_ready_i;

  // RAM access
  assign new_rule.accept   = rq_q.rule_accept;
  assign new_rule.proto    = rq_q.rule_proto;
  assign new_rule.src_addr = rq_q.src_addr;
  assign new_rule.dst_addr = rq_q.dst_addr;
  assign new_rule.src_port = rq_q.src_port;
  assign new_rule.dst_port = rq_q.dst_port;

  assign shift_pos = chk_pos_q - CntW'(1);
  assign ram_re    = ((cmd_i.scan && !hit_now) || cmd_i.shift) && more;
  assign rd_addr   = rd_ptr_q[IdxW-1:0];
  assign ram_we    = (cmd_i.decode && (rq_q.req_type == fmprf_pkg::ReqAppend) && !full)
                  || (cmd_i.shift && chk_vld_q);
  assign wr_addr   = cmd_i.shift ? shift_pos[IdxW-1:0] : total_q[IdxW-1:0];
  assign wr_rule   = cmd_i.shift ? rd_rule : new_rule;

  fmprf_ram #(
    .Width ($bits(fmprf_pkg::rule_t)),
    .Depth (MAX_RULES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_rule),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (rd_rule)
  );

  always_comb begin
    rq_d      = cmd_i.capture ? req_i : rq_q;
    res_d     = res_q;
    total_d   = total_q;
    rd_ptr_d  = ram_re ? (rd_ptr_q + CntW'(1)) : rd_ptr_q;
    chk_vld_d = ram_re;
    chk_pos_d = ram_re ? rd_ptr_q : chk_pos_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;

    if (cmd_i.decode) begin
      res_d = '0;
      case (rq_q.req_type)
        fmprf_pkg::ReqAppend: begin
          if (full) res_d.status = fmprf_pkg::StFull;
          else total_d = total_q + CntW'(1);
        end
        fmprf_pkg::ReqDelete: begin
          if (bad_del) res_d.status = fmprf_pkg::StNoIndex;
          else rd_ptr_d = ridx_ext[CntW-1:0];
        end
        fmprf_pkg::ReqClear: begin
          total_d = '0;
        end
        default: begin
          rd_ptr_d = '0;
          if (!filter_enable_i) res_d.verdict_accept = 1'b1;
          else if (!scan_ok) res_d.verdict_accept = 1'b0;
          else res_d.verdict_accept = default_accept_i;
        end
      endcase
    end

    if (cmd_i.scan && hit_now) begin
      res_d.verdict_accept = rd_rule.accept;
      res_d.rule_hit       = 1'b1;
      res_d.hit_position   = fmprf_pkg::PosW'(chk_pos_q + CntW'(1));
    end

    if (cmd_i.shift && sts_o.shift_done) begin
      total_d = total_q - CntW'(1);
    end

    if (cmd_i.load_out) begin
      out_d            = res_q;
      out_d.rules_held = fmprf_pkg::PosW'(total_q);
      out_vld_d        = 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      total_q   <= total_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q      <= rq_d;
    res_q     <= res_d;
    rd_ptr_q  <= rd_ptr_d;
    chk_pos_q <= chk_pos_d;
    out_q     <= out_d;
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;

`ifndef SYNTH
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(MAX_RULES))
    else $error("rule count above table size");

  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.decode || cmd_i.shift) |=> total_q == $past(total_q))
    else $error("rule count changed outside decode or shift");

  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> wr_addr != rd_addr)
    else $error("RAM read and write hit the same entry");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_vld_q || rsp_ready_i))
    else $error("response loaded over a pending one");
`endif

endmodule

// File: hw/rtl/first_match_packet_rule_filter_top.sv
// Top level of the first-match packet rule filter.
// One request in flight: append and clear go from accept through decode to response load.
// Classify scans the rules in order, one rule RAM read per cycle, until the first hit or the end.
// Delete moves each rule behind the deleted index one place forward, one rule moved per cycle.
// A new request is taken while the last response still waits at the output register.
// Reset empties the table, sets default_accept to 1 and filter_enable to 0.
module first_match_packet_rule_filter_top #(
  parameter int unsigned MAX_RULES = fmprf_pkg::MaxRulesDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  fmprf_chan_if.sink   req_i,
  fmprf_chan_if.source rsp_o,
  fmprf_chan_if.sink   cfg_i
);

  fmprf_pkg::ctrl_cmd_t cmd;
  fmprf_pkg::dp_sts_t   sts;
  logic                 default_accept_q;
  logic                 filter_enable_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_accept_q <= 1'b1;
      filter_enable_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.idx)
        fmprf_pkg::CfgDefaultAccept: default_accept_q <= cfg_i.payload.data;
        fmprf_pkg::CfgFilterEnable:  filter_enable_q  <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  fmprf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fmprf_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_i.payload),
    .default_accept_i (default_accept_q),
    .filter_enable_i  (filter_enable_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_o            (rsp_o.payload)
  );

endmodule

// File: test/tb_first_match_packet_rule_filter_top.sv
// Testbench for the first-match packet rule filter: directed and random requests, scoreboard check.
`timescale 1ns / 100ps

module tb_first_match_packet_rule_filter_top;

  localparam int unsigned Depth      = fmprf_pkg::MaxRulesDef;
  localparam int unsigned PhaseItems = 230;
  localparam int unsigned NumPhases  = 8;

  // request mix per profile: fill, churn, scan
  localparam int AppendPct[3] = '{70, 30, 8};
  localparam int DeletePct[3] = '{5, 20, 4};
  localparam int ClearPct[3]  = '{0, 3, 1};

  localparam logic [31:0] AddrPool[4] = '{32'h0A00_0001, 32'hC0A8_0101, 32'hFFFF_FFFF,
                                          32'h8000_0000};
  localparam logic [15:0] PortPool[4] = '{16'd80, 16'd443, 16'd53, 16'hFFFF};

  localparam logic DfltSet[NumPhases] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam logic EnSet[NumPhases]   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam int   ProfSet[NumPhases] = '{0, 1, 2, 2, 1, 1, 0, 2};
  localparam bit   GapSet[NumPhases]  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

  class rule_list_scoreboard;
    fmprf_pkg::rule_t rules[Depth];
    int unsigned      held;
    logic             dflt_accept;
    logic             filt_enable;
    fmprf_pkg::rsp_t  pending_rsp[$];
    int unsigned      fail_count;
    int unsigned      rsp_count;
    int unsigned      req_count[4];
    int unsigned      hit_count;
    int unsigned      full_count;
    int unsigned      bad_idx_count;

    function new();
      held        = 0;
      dflt_accept = 1'b1;
      filt_enable = 1'b0;
    endfunction

    function void set_reg(logic [fmprf_pkg::CfgIdxW-1:0] idx, logic data);
      if (idx == fmprf_pkg::CfgDefaultAccept) dflt_accept = data;
      else if (idx == fmprf_pkg::CfgFilterEnable) filt_enable = data;
    endfunction

    function bit term_ok(logic [31:0] want, logic [31:0] seen);
      return want == '0 || want == seen;
    endfunction

    function void note_request(fmprf_pkg::req_t r);
      fmprf_pkg::rsp_t e;
      logic [15:0]     psp;
      logic [15:0]     pdp;
      int unsigned     i;
      e = '0;
      req_count[r.req_type]++;
      case (fmprf_pkg::req_type_e'(r.req_type))
        fmprf_pkg::ReqAppend: begin
          if (held >= Depth) begin
            e.status = fmprf_pkg::StFull;
            full_count++;
          end else begin
            rules[held] = fmprf_pkg::rule_t'{accept: r.rule_accept, proto: r.rule_proto,
                                             src_addr: r.src_addr, dst_addr: r.dst_addr,
                                             src_port: r.src_port, dst_port: r.dst_port};
            held++;
          end
        end
        fmprf_pkg::ReqDelete: begin
          if (r.rule_index == '0 || 32'(r.rule_index) > held) begin
            e.status = fmprf_pkg::StNoIndex;
            bad_idx_count++;
          end else begin
            for (i = 32'(r.rule_index) - 1; i + 1 < held; i++) rules[i] = rules[i + 1];
            held--;
          end
        end
        fmprf_pkg::ReqClear: held = 0;
        default: begin
          if (!filt_enable) begin
            e.verdict_accept = 1'b1;
          end else if (r.ip_proto == fmprf_pkg::ProtoOther) begin
            e.verdict_accept = 1'b0;
          end else begin
            // ICMP carries no ports
            psp = (r.ip_proto == fmprf_pkg::ProtoIcmp) ? '0 : r.src_port;
            pdp = (r.ip_proto == fmprf_pkg::ProtoIcmp) ? '0 : r.dst_port;
            e.verdict_accept = dflt_accept;
            for (i = 0; i < held; i++) begin
              if ((rules[i].proto == r.ip_proto || rules[i].proto == fmprf_pkg::ProtoAny) &&
                  term_ok(rules[i].src_addr, r.src_addr) &&
                  term_ok(rules[i].dst_addr, r.dst_addr) &&
                  term_ok(32'(rules[i].src_port), 32'(psp)) &&
                  term_ok(32'(rules[i].dst_port), 32'(pdp))) begin
                e.verdict_accept = rules[i].accept;
                e.rule_hit       = 1'b1;
                e.hit_position   = fmprf_pkg::PosW'(i + 1);
                hit_count++;
                break;
              end
            end
          end
        end
      endcase
      e.rules_held = fmprf_pkg::PosW'(held);
      pending_rsp.push_back(e);
    endfunction

    task report(string msg);
      if (fail_count < 40) $display("MISMATCH response %0d: %s", rsp_count, msg);
      fail_count++;
    endtask

    task check_response(fmprf_pkg::rsp_t got);
      fmprf_pkg::rsp_t e;
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        report($sformatf("unexpected response %h", got));
        return;
      end
      e = pending_rsp.pop_front();
      if (got.verdict_accept !== e.verdict_accept)
        report($sformatf("verdict_accept %b, want %b", got.verdict_accept, e.verdict_accept));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.rule_hit !== e.rule_hit)
        report($sformatf("rule_hit %b, want %b", got.rule_hit, e.rule_hit));
      if (got.hit_position !== e.hit_position)
        report($sformatf("hit_position %0d, want %0d", got.hit_position, e.hit_position));
      if (got.rules_held !== e.rules_held)
        report($sformatf("rules_held %0d, want %0d", got.rules_held, e.rules_held));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  fmprf_chan_if #(.T(fmprf_pkg::req_t)) req_if ();
  fmprf_chan_if #(.T(fmprf_pkg::rsp_t)) rsp_if ();
  fmprf_chan_if #(.T(fmprf_pkg::cfg_t)) cfg_if ();

  rule_list_scoreboard sb = new();

  first_match_packet_rule_filter_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
  end

  // receiver: switches between randomly chosen stall patterns
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 200);
      for (tick = 0; tick < span; tick++) begin
        @(posedge clk_i);
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= (tick % 9) < 3;
        endcase
      end
    end
  end

  function automatic fmprf_pkg::req_t rand_req();
    fmprf_pkg::req_t r;
    r.req_type    = 2'($urandom);
    r.ip_proto    = 2'($urandom);
    r.src_addr    = $urandom;
    r.dst_addr    = $urandom;
    r.src_port    = 16'($urandom);
    r.dst_port    = 16'($urandom);
    r.rule_proto  = 2'($urandom);
    r.rule_accept = 1'($urandom);
    r.rule_index  = fmprf_pkg::PosW'($urandom);
    return r;
  endfunction

  function automatic logic [31:0] pool_addr();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return '0;
    if (roll < 80) return AddrPool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic logic [15:0] pool_port();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return '0;
    if (roll < 80) return PortPool[$urandom_range(0, 3)];
    return 16'($urandom);
  endfunction

  function automatic fmprf_pkg::req_t directed_req(fmprf_pkg::req_type_e kind,
                                                   logic [1:0] proto, logic [31:0] sa,
                                                   logic [31:0] da, logic [15:0] sp,
                                                   logic [15:0] dp, logic acc,
                                                   logic [fmprf_pkg::PosW-1:0] idx);
    fmprf_pkg::req_t r;
    r             = rand_req();
    r.req_type    = kind;
    r.ip_proto    = proto;
    r.rule_proto  = proto;
    r.src_addr    = sa;
    r.dst_addr    = da;
    r.src_port    = sp;
    r.dst_port    = dp;
    r.rule_accept = acc;
    r.rule_index  = idx;
    return r;
  endfunction

  function automatic fmprf_pkg::req_t make_request(int profile);
    fmprf_pkg::req_t  r;
    fmprf_pkg::rule_t pick;
    int               roll;
    r    = rand_req();
    roll = $urandom_range(0, 99);
    if (roll < AppendPct[profile]) begin
      r.req_type = fmprf_pkg::ReqAppend;
      r.src_addr = pool_addr();
      r.dst_addr = pool_addr();
      r.src_port = pool_port();
      r.dst_port = pool_port();
    end else if (roll < AppendPct[profile] + DeletePct[profile]) begin
      r.req_type = fmprf_pkg::ReqDelete;
      if (sb.held > 0 && $urandom_range(0, 99) < 80)
        r.rule_index = fmprf_pkg::PosW'($urandom_range(1, sb.held));
    end else if (roll < AppendPct[profile] + DeletePct[profile] + ClearPct[profile]) begin
      r.req_type = fmprf_pkg::ReqClear;
    end else begin
      r.req_type = fmprf_pkg::ReqClassify;
      if (sb.held > 0 && $urandom_range(0, 99) < 65) begin
        // aim at a held rule, filling its don't-care fields from the pools
        pick       = sb.rules[$urandom_range(0, sb.held - 1)];
        r.ip_proto = (pick.proto == fmprf_pkg::ProtoAny) ? 2'($urandom_range(0, 2))
                                                          : pick.proto;
        r.src_addr = (pick.src_addr != '0) ? pick.src_addr : pool_addr();
        r.dst_addr = (pick.dst_addr != '0) ? pick.dst_addr : pool_addr();
        r.src_port = (pick.src_port != '0) ? pick.src_port : pool_port();
        r.dst_port = (pick.dst_port != '0) ? pick.dst_port : pool_port();
        if ($urandom_range(0, 99) < 8) r.ip_proto = 2'($urandom);
      end else begin
        r.src_addr = pool_addr();
        r.dst_addr = pool_addr();
        r.src_port = pool_port();
        r.dst_port = pool_port();
      end
    end
    return r;
  endfunction

  task automatic send_req(fmprf_pkg::req_t r);
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_apply(logic dflt, logic en);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= fmprf_pkg::cfg_t'{idx: fmprf_pkg::CfgDefaultAccept, data: dflt};
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(fmprf_pkg::CfgDefaultAccept, dflt);
    cfg_if.payload <= fmprf_pkg::cfg_t'{idx: fmprf_pkg::CfgFilterEnable, data: en};
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(fmprf_pkg::CfgFilterEnable, en);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic directed();
    // filtering off after reset
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoTcp, 32'hC0A8_0001,
                          32'h0A00_0002, 16'd1000, 16'd80, 1'b0, '0));
    drain();
    cfg_apply(1'b1, 1'b1);
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoUdp, 32'h0102_0304,
                          32'h0506_0708, 16'd9, 16'd9, 1'b0, '0));
    send_req(directed_req(fmprf_pkg::ReqAppend, fmprf_pkg::ProtoTcp, 32'hFFFF_FFFF, '0,
                          16'hFFFF, '0, 1'b0, '0));
    send_req(directed_req(fmprf_pkg::ReqAppend, fmprf_pkg::ProtoIcmp, 32'h0A00_0001, '0,
                          '0, '0, 1'b0, '0));
    send_req(directed_req(fmprf_pkg::ReqAppend, fmprf_pkg::ProtoUdp, '0, '0, '0, 16'd53,
                          1'b0, '0));
    // port on an ICMP rule: never hits
    send_req(directed_req(fmprf_pkg::ReqAppend, fmprf_pkg::ProtoIcmp, '0, '0, '0, 16'd7,
                          1'b1, '0));
    send_req(directed_req(fmprf_pkg::ReqAppend, fmprf_pkg::ProtoAny, '0, '0, '0, '0, 1'b1,
                          fmprf_pkg::PosW'(127)));
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoTcp, 32'hFFFF_FFFF,
                          32'h0102_0304, 16'hFFFF, 16'd80, 1'b1, '0));
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoIcmp, 32'h0A00_0001,
                          32'h0909_0909, 16'd1234, 16'd99, 1'b0, '0));
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoIcmp, 32'h0B00_0001,
                          32'h0909_0909, '0, 16'd7, 1'b0, '0));
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoUdp, 32'h0101_0101,
                          32'h0808_0808, 16'd5353, 16'd53, 1'b0, '0));
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoOther, 32'hFFFF_FFFF,
                          '0, 16'hFFFF, '0, 1'b1, '0));
    send_req(directed_req(fmprf_pkg::ReqDelete, fmprf_pkg::ProtoTcp, '0, '0, '0, '0, 1'b0,
                          '0));
    send_req(directed_req(fmprf_pkg::ReqDelete, fmprf_pkg::ProtoTcp, '0, '0, '0, '0, 1'b0,
                          fmprf_pkg::PosW'(127)));
    send_req(directed_req(fmprf_pkg::ReqDelete, fmprf_pkg::ProtoTcp, '0, '0, '0, '0, 1'b0,
                          fmprf_pkg::PosW'(6)));
    send_req(directed_req(fmprf_pkg::ReqDelete, fmprf_pkg::ProtoTcp, '0, '0, '0, '0, 1'b0,
                          fmprf_pkg::PosW'(1)));
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoTcp, 32'hFFFF_FFFF,
                          32'h0102_0304, 16'hFFFF, 16'd80, 1'b0, '0));
    send_req(directed_req(fmprf_pkg::ReqDelete, fmprf_pkg::ProtoTcp, '0, '0, '0, '0, 1'b0,
                          fmprf_pkg::PosW'(4)));
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoTcp, 32'hFFFF_FFFF,
                          32'h0102_0304, 16'hFFFF, 16'd80, 1'b0, '0));
    drain();
    cfg_apply(1'b0, 1'b1);
    send_req(directed_req(fmprf_pkg::ReqClassify, fmprf_pkg::ProtoTcp, 32'h1111_1111,
                          32'h2222_2222, 16'd1, 16'd2, 1'b0, '0));
    send_req(directed_req(fmprf_pkg::ReqClear, fmprf_pkg::ProtoTcp, '0, '0, '0, '0, 1'b0,
                          '0));
    send_req(directed_req(fmprf_pkg::ReqDelete, fmprf_pkg::ProtoTcp, '0, '0, '0, '0, 1'b0,
                          fmprf_pkg::PosW'(1)));
    drain();
  endtask

  task automatic run_phase(int profile, bit gaps);
    int left;
    int burst;
    left = PhaseItems;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_req(make_request(profile));
      left -= burst;
      if ($urandom_range(0, 19) == 0) begin
        drain();
      end else if (gaps) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    for (int p = 0; p < NumPhases; p++) begin
      cfg_apply(DfltSet[p], EnSet[p]);
      run_phase(ProfSet[p], GapSet[p]);
    end
    repeat (100) @(posedge clk_i);
    $display("Covered %0d appends (%0d on a full list), %0d deletes (%0d bad index), %0d clears",
             sb.req_count[fmprf_pkg::ReqAppend], sb.full_count,
             sb.req_count[fmprf_pkg::ReqDelete], sb.bad_idx_count,
             sb.req_count[fmprf_pkg::ReqClear]);
    $display("Covered %0d classify requests, %0d decided by a rule; %0d responses, %0d mismatches",
             sb.req_count[fmprf_pkg::ReqClassify], sb.hit_count, sb.rsp_count, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d responses outstanding", sb.pending_rsp.size());
    $display("FAILURE");
    $finish;
  end

endmodule
